@@ src/tic_pkg.sv @@
// Shared constants for the triangular inverse CDF block.
// No dependencies; used by triangular_inverse_cdf.
package tic_pkg;

  localparam int unsigned CoordWidthDef   = 32;
  localparam int unsigned ProbFracBitsDef = 16;
  localparam int unsigned CfgAddrWidth    = 3;
  localparam int unsigned StatusWidth     = 2;

  // register indexes on the configuration port
  localparam logic [CfgAddrWidth-1:0] RegBoundsEnabled = 3'd0;
  localparam logic [CfgAddrWidth-1:0] RegModeValue     = 3'd1;
  localparam logic [CfgAddrWidth-1:0] RegHalfWidth     = 3'd2;
  localparam logic [CfgAddrWidth-1:0] RegLowerBound    = 3'd3;
  localparam logic [CfgAddrWidth-1:0] RegUpperBound    = 3'd4;

  // result status codes
  localparam logic [StatusWidth-1:0] StatusOk        = 2'd0;
  localparam logic [StatusWidth-1:0] StatusLowNotLow = 2'd1;
  localparam logic [StatusWidth-1:0] StatusLowAbove  = 2'd2;
  localparam logic [StatusWidth-1:0] StatusModeAbove = 2'd3;

endpackage

@@ src/triangular_inverse_cdf.sv @@
// Top level of the triangular inverse CDF block.
// Depends on tic_pkg and tic_root_cell.
//
// Usage: each input word on s_axis carries a probability in Q0.PROB_FRAC_BITS
// (2^PROB_FRAC_BITS means one; larger values count as one). Each word yields
// one output word on m_axis with the quantile (signed Q16.16, saturated) and a
// status code. The distribution is set on the cfg port: mode, and either a half
// width around it or explicit lower and upper bounds. Write it only while idle.
// Invalid bounds give a nonzero status and a quantile of zero.
//
// Structure: COORD_WIDTH + 5 register stages (four front stages: clamp, compare
// product, span product, scaled product; one root cell per result bit; one
// output stage). Throughput: one word per cycle while the receiver keeps up,
// as each root cell takes a new word every cycle in which the cell after it
// is empty or moving. Every stage holds its own valid bit and moves when
// the stage after it is empty or moving, so a stalled receiver first lets
// bubbles collapse and then holds all words in place; nothing is dropped.
// Reset empties all stages and loads the reset configuration.
module triangular_inverse_cdf #(
  parameter int unsigned COORD_WIDTH    = tic_pkg::CoordWidthDef,
  parameter int unsigned PROB_FRAC_BITS = tic_pkg::ProbFracBitsDef,
  localparam int unsigned InW  = ((PROB_FRAC_BITS + 1 + 7) / 8) * 8,
  localparam int unsigned OutW = ((COORD_WIDTH + tic_pkg::StatusWidth + 7) / 8) * 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [tic_pkg::CfgAddrWidth-1:0] cfg_addr_i,
  input  logic [COORD_WIDTH-1:0]          cfg_data_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [InW-1:0]                  s_axis_tdata,  // probability
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [OutW-1:0]                 m_axis_tdata   // quantile_value, status
);

  localparam int unsigned CW  = COORD_WIDTH;
  localparam int unsigned PB  = PROB_FRAC_BITS;
  localparam int unsigned XW  = 2 * CW;
  localparam int unsigned SW  = CW + 1 + 1 + tic_pkg::StatusWidth;
  localparam logic [PB:0] ProbOne = (PB+1)'(1) << PB;

  // ---------------- configuration registers ----------------
  logic          bounds_en_q;
  logic [CW-1:0] mode_q, lower_q, upper_q;
  logic [CW-2:0] half_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bounds_en_q <= 1'b0;
      mode_q      <= '0;
      half_q      <= (CW-1)'(65536);
      lower_q     <= CW'(-65536);
      upper_q     <= CW'(65536);
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        tic_pkg::RegBoundsEnabled: bounds_en_q <= cfg_data_i[0];
        tic_pkg::RegModeValue:     mode_q      <= cfg_data_i;
        tic_pkg::RegHalfWidth:     half_q      <= cfg_data_i[CW-2:0];
        tic_pkg::RegLowerBound:    lower_q     <= cfg_data_i;
        tic_pkg::RegUpperBound:    upper_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------- derived support, refreshed every cycle ----------------
  logic signed [CW:0] a_c, b_c, c_c, a_q, b_q;
  logic signed [CW:0] span_c, left_c, right_c;
  logic [CW-1:0]      span_q, left_q, right_q;
  logic [tic_pkg::StatusWidth-1:0] st_c, st_q;

  always_comb begin
    c_c = {mode_q[CW-1], mode_q};
    if (bounds_en_q) begin
      a_c = {lower_q[CW-1], lower_q};
      b_c = {upper_q[CW-1], upper_q};
    end else begin
      a_c = c_c - $signed({2'b00, half_q});
      b_c = c_c + $signed({2'b00, half_q});
    end
    if (!bounds_en_q)  st_c = tic_pkg::StatusOk;
    else if (a_c >= b_c) st_c = tic_pkg::StatusLowNotLow;
    else if (a_c > c_c)  st_c = tic_pkg::StatusLowAbove;
    else if (c_c > b_c)  st_c = tic_pkg::StatusModeAbove;
    else                 st_c = tic_pkg::StatusOk;
    span_c  = b_c - a_c;
    left_c  = c_c - a_c;
    right_c = b_c - c_c;
  end

  always_ff @(posedge clk_i) begin
    a_q     <= a_c;
    b_q     <= b_c;
    st_q    <= st_c;
    span_q  <= span_c[CW-1:0];
    left_q  <= left_c[CW-1:0];
    right_q <= right_c[CW-1:0];
  end

  // ---------------- front stages ----------------
  // stage 1: clamp probability
  logic        v1_q, r1;
  logic [PB:0] pr1_q;
  logic [PB:0] pr_in;

  // stage 2: compare product
  logic           v2_q, r2;
  logic [PB:0]    pr2_q;
  logic [CW+PB:0] mull_q;

  // stage 3: branch select, span product
  logic          v3_q, r3;
  logic          sel3_q;
  logic [PB:0]   pp3_q;
  logic [XW-1:0] prod3_q;
  logic          sel2;
  logic [CW+PB:0] lefts2;

  // stage 4: scaled product feeding the root chain
  logic           v4_q, r4;
  logic [XW-1:0]  x4_q;
  logic [SW-1:0]  side4_q;
  logic [XW+PB:0] full3;

  logic rc0;  // ready of first root cell

  assign pr_in = s_axis_tdata[PB:0];

  assign r4 = !v4_q || rc0;
  assign r3 = !v3_q || r4;
  assign r2 = !v2_q || r3;
  assign r1 = !v1_q || r2;
  assign s_axis_tready = r1;

  assign lefts2 = {{(PB+1){1'b0}}, left_q} << PB;
  assign sel2   = (mull_q <= lefts2);
  assign full3  = {{(PB+1){1'b0}}, prod3_q} * {{XW{1'b0}}, pp3_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (r1) v1_q <= s_axis_tvalid;
      if (r2) v2_q <= v1_q;
      if (r3) v3_q <= v2_q;
      if (r4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && r1) begin
      pr1_q <= (pr_in > ProbOne) ? ProbOne : pr_in;
    end
    if (v1_q && r2) begin
      pr2_q  <= pr1_q;
      mull_q <= {{CW{1'b0}}, pr1_q} * {{(PB+1){1'b0}}, span_q};
    end
    if (v2_q && r3) begin
      sel3_q  <= sel2;
      pp3_q   <= sel2 ? pr2_q : ProbOne - pr2_q;
      prod3_q <= {{CW{1'b0}}, span_q} * {{CW{1'b0}}, (sel2 ? left_q : right_q)};
    end
    if (v3_q && r4) begin
      if (st_q != tic_pkg::StatusOk) begin
        x4_q    <= '0;
        side4_q <= {st_q, 1'b1, {(CW+1){1'b0}}};
      end else begin
        x4_q    <= full3[XW+PB-1:PB];
        side4_q <= {st_q, sel3_q, (sel3_q ? a_q : b_q)};
      end
    end
  end

  // ---------------- root chain ----------------
  logic          cv   [CW+1];
  logic          cr   [CW+1];
  logic [XW-1:0] crem [CW+1];
  logic [XW-1:0] cres [CW+1];
  logic [SW-1:0] cside[CW+1];

  assign cv[0]    = v4_q;
  assign crem[0]  = x4_q;
  assign cres[0]  = '0;
  assign cside[0] = side4_q;
  assign rc0      = cr[0];

  for (genvar k = 0; k < CW; k++) begin : g_cell
    tic_root_cell #(
      .XW   (XW),
      .SW   (SW),
      .SHIFT(2 * (CW - 1 - k))
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(cv[k]),
      .ready_o(cr[k]),
      .rem_i  (crem[k]),
      .res_i  (cres[k]),
      .side_i (cside[k]),
      .valid_o(cv[k+1]),
      .ready_i(cr[k+1]),
      .rem_o  (crem[k+1]),
      .res_o  (cres[k+1]),
      .side_o (cside[k+1])
    );
  end

  // ---------------- output stage ----------------
  logic                 out_v_q;
  logic [CW-1:0]        q_q;
  logic [tic_pkg::StatusWidth-1:0] ost_q;
  logic signed [CW+1:0] base_e, root_e, qsum;
  logic signed [CW+1:0] qmax, qmin;
  logic [CW-1:0]        q_sat;

  assign cr[CW] = !out_v_q || m_axis_tready;

  always_comb begin
    base_e = {cside[CW][CW], cside[CW][CW:0]};
    root_e = $signed({2'b00, cres[CW][CW-1:0]});
    qmax   = $signed({3'b000, {(CW-1){1'b1}}});
    qmin   = -qmax - (CW+2)'(1);
    qsum   = cside[CW][CW+1] ? base_e + root_e : base_e - root_e;
    if (qsum > qmax)      q_sat = qmax[CW-1:0];
    else if (qsum < qmin) q_sat = qmin[CW-1:0];
    else                  q_sat = qsum[CW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (cr[CW]) begin
      out_v_q <= cv[CW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cv[CW] && cr[CW]) begin
      q_q   <= q_sat;
      ost_q <= cside[CW][SW-1 -: tic_pkg::StatusWidth];
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = OutW'({ost_q, q_q});

endmodule

@@ src/tic_root_cell.sv @@
// One cell of the square-root chain: settles one result bit per word.
// Depends on no package items; instantiated by triangular_inverse_cdf.
module tic_root_cell #(
  parameter int unsigned XW    = 64,
  parameter int unsigned SW    = 36,
  parameter int unsigned SHIFT = 62
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  logic [XW-1:0] rem_i,
  input  logic [XW-1:0] res_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  input  logic          ready_i,
  output logic [XW-1:0] rem_o,
  output logic [XW-1:0] res_o,
  output logic [SW-1:0] side_o
);

  localparam logic [XW-1:0] One = XW'(1) << SHIFT;

  logic          valid_q;
  logic [XW-1:0] rem_q, rem_d, res_q, res_d;
  logic [SW-1:0] side_q;
  logic [XW:0]   trial;
  logic          load;

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;

  always_comb begin
    trial = {1'b0, res_i} + {1'b0, One};
    if ({1'b0, rem_i} >= trial) begin
      rem_d = rem_i - trial[XW-1:0];
      res_d = (res_i >> 1) + One;
    end else begin
      rem_d = rem_i;
      res_d = res_i >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      rem_q  <= rem_d;
      res_q  <= res_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign res_o   = res_q;
  assign side_o  = side_q;

endmodule
